[design/pli_pkg.sv]
// shared types and constants for the piecewise linear interpolator
`timescale 1ns / 1ps
`default_nettype none
package pli_pkg;
	localparam int MaxPoints = 64;
	localparam int AddrW = $clog2(MaxPoints);
	localparam int CntW = $clog2(MaxPoints + 1);

	typedef enum logic [1:0] {
		KIND_CLEAR = 2'd0,
		KIND_LOAD  = 2'd1,
		KIND_QUERY = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_DUP   = 2'd1,
		ST_FULL  = 2'd2,
		ST_SHORT = 2'd3
	} status_t;

	typedef struct packed {
		logic        start;
		logic [63:0] num;
		logic [31:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quo;
	} div_rsp_t;
endpackage
`default_nettype wire

[design/pli_ram.sv]
// single-port breakpoint memory with registered read, x and y side by side
`timescale 1ns / 1ps
`default_nettype none
module pli_ram (
	input  wire                           clk,
	input  wire                           we,
	input  wire [pli_pkg::AddrW-1:0]      addr,
	input  wire [63:0]                    wdata,
	output logic [63:0]                   rdata
);
	logic [63:0] mem [pli_pkg::MaxPoints];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

[design/pli_div.sv]
// restoring divider, 64-bit dividend by 32-bit positive divisor, one bit a cycle
`timescale 1ns / 1ps
`default_nettype none
module pli_div (
	input  wire                clk,
	input  wire                arst_n,
	input  pli_pkg::div_req_t  req,
	output pli_pkg::div_rsp_t  rsp
);
	logic [63:0] quo_q;
	logic [32:0] rem_q;
	logic [31:0] den_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] trial;
	logic [33:0] diff;

	assign trial = {rem_q[31:0], quo_q[63]};
	assign diff = {1'b0, trial} - {2'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			// pulse after the last quotient bit
			done_q <= busy_q && !req.start && (cnt_q == 7'd1);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'd64;
				quo_q <= req.num;
				rem_q <= '0;
				den_q <= req.den;
			end else if (busy_q) begin
				if (!diff[33]) begin
					rem_q <= diff[32:0];
					quo_q <= {quo_q[62:0], 1'b1};
				end else begin
					rem_q <= trial;
					quo_q <= {quo_q[62:0], 1'b0};
				end
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
				end
			end
		end
	end
	assign rsp = pli_pkg::div_rsp_t'{done: done_q, quo: quo_q};
endmodule
`default_nettype wire

[design/pli_ctrl.sv]
// sequencer: binary search, insertion shift and interpolation over the memory
`timescale 1ns / 1ps
`default_nettype none
module pli_ctrl (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire [1:0]                    in_kind,
	input  wire signed [31:0]            in_x,
	input  wire signed [31:0]            in_y,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic [31:0]                  out_y,
	output logic [1:0]                   out_status,
	output logic [6:0]                   out_count,
	output logic                         ram_we,
	output logic [pli_pkg::AddrW-1:0]    ram_addr,
	output logic [63:0]                  ram_wdata,
	input  wire [63:0]                   ram_rdata,
	output pli_pkg::div_req_t            div_req,
	input  pli_pkg::div_rsp_t            div_rsp
);
	localparam int AW = pli_pkg::AddrW;
	localparam int CW = pli_pkg::CntW;

	typedef enum logic [3:0] {
		S_IDLE, S_SRCH, S_SRCH_W, S_DECIDE, S_SHIFT_R, S_SHIFT_W, S_PUT,
		S_RD_A, S_RD_B, S_GOT_A, S_GOT_B, S_MUL, S_SUM, S_DIV, S_OUT
	} state_t;

	state_t state_q;
	logic [CW-1:0] count_q, lo_q, hi_q, k_q, mid;
	logic [1:0] kind_q;
	logic signed [31:0] x_q, y_q, xa_q, ya_q, xb_q, yb_q;
	logic signed [32:0] w1_q, w2_q;
	logic signed [65:0] p1_q, p2_q;
	logic signed [66:0] sum;
	logic neg_q, dup_q;
	logic start_q;
	logic [63:0] num_q;
	logic [31:0] den_q;
	logic [CW-1:0] seg;
	logic signed [31:0] rx;

	assign mid = lo_q + ((hi_q - lo_q) >> 1);
	assign rx = ram_rdata[31:0];
	assign sum = {p1_q[65], p1_q} + {p2_q[65], p2_q};
	assign in_ready = (state_q == S_IDLE) && !out_valid;
	// segment end clamped to 1 .. count-1
	assign seg = (lo_q < CW'(1)) ? CW'(1) :
		(lo_q > count_q - CW'(1)) ? count_q - CW'(1) : lo_q;
	assign div_req = pli_pkg::div_req_t'{start: start_q, num: num_q, den: den_q};

	always_comb begin
		ram_we = 1'b0;
		ram_addr = mid[AW-1:0];
		ram_wdata = {y_q, x_q};
		case (state_q)
			S_SHIFT_R: ram_addr = AW'(k_q - CW'(1));
			S_SHIFT_W: begin
				ram_we = 1'b1;
				ram_addr = k_q[AW-1:0];
				ram_wdata = ram_rdata;
			end
			S_PUT: begin
				ram_we = 1'b1;
				ram_addr = lo_q[AW-1:0];
			end
			S_RD_A: ram_addr = AW'(seg - CW'(1));
			S_RD_B, S_GOT_A: ram_addr = seg[AW-1:0];
			default: ram_addr = mid[AW-1:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			out_valid <= 1'b0;
			start_q <= 1'b0;
		end else begin
			start_q <= (state_q == S_SUM) && dup_q;
			if (state_q == S_OUT) out_valid <= 1'b1;
			else if (out_valid && out_ready) out_valid <= 1'b0;
			case (state_q)
				S_IDLE: if (in_valid && in_ready) begin
					kind_q <= in_kind;
					x_q <= in_x;
					y_q <= in_y;
					lo_q <= '0;
					hi_q <= count_q;
					out_y <= '0;
					out_status <= pli_pkg::ST_OK;
					case (pli_pkg::kind_t'(in_kind))
						pli_pkg::KIND_CLEAR: begin
							count_q <= '0;
							state_q <= S_OUT;
						end
						pli_pkg::KIND_LOAD: state_q <= S_SRCH;
						pli_pkg::KIND_QUERY: begin
							if (count_q < CW'(2)) begin
								out_status <= pli_pkg::ST_SHORT;
								state_q <= S_OUT;
							end else state_q <= S_SRCH;
						end
						default: state_q <= S_OUT;
					endcase
				end
				S_SRCH: begin
					if (lo_q < hi_q) state_q <= S_SRCH_W;
					else state_q <= S_DECIDE;
				end
				S_SRCH_W: begin
					if (rx < x_q) lo_q <= mid + CW'(1);
					else hi_q <= mid;
					state_q <= S_SRCH;
				end
				S_DECIDE: begin
					// one read of entry lo for the duplicate check
					if (kind_q == pli_pkg::KIND_QUERY) state_q <= S_RD_A;
					else begin
						hi_q <= lo_q;
						state_q <= S_GOT_B;
						dup_q <= 1'b0;
					end
				end
				S_GOT_B: begin
					// ram_addr was mid == lo in S_DECIDE
					if (lo_q < count_q && rx == x_q) begin
						out_status <= pli_pkg::ST_DUP;
						state_q <= S_OUT;
					end else if (count_q >= CW'(pli_pkg::MaxPoints)) begin
						out_status <= pli_pkg::ST_FULL;
						state_q <= S_OUT;
					end else begin
						k_q <= count_q;
						state_q <= (count_q > lo_q) ? S_SHIFT_R : S_PUT;
					end
				end
				S_SHIFT_R: state_q <= S_SHIFT_W;
				S_SHIFT_W: begin
					k_q <= k_q - CW'(1);
					state_q <= (k_q - CW'(1) > lo_q) ? S_SHIFT_R : S_PUT;
				end
				S_PUT: begin
					count_q <= count_q + CW'(1);
					state_q <= S_OUT;
				end
				S_RD_A: state_q <= S_RD_B;
				S_RD_B: begin
					xa_q <= rx;
					ya_q <= ram_rdata[63:32];
					state_q <= S_GOT_A;
				end
				S_GOT_A: begin
					xb_q <= rx;
					yb_q <= ram_rdata[63:32];
					state_q <= S_MUL;
				end
				S_MUL: begin
					w1_q <= {xb_q[31], xb_q} - {x_q[31], x_q};
					w2_q <= {x_q[31], x_q} - {xa_q[31], xa_q};
					state_q <= S_SUM;
					p1_q <= '0;
					dup_q <= 1'b0;
				end
				S_SUM: begin
					// first pass multiplies, second pass forms the signed sum
					if (!dup_q) begin
						p1_q <= w1_q * ya_q;
						p2_q <= w2_q * yb_q;
						dup_q <= 1'b1;
					end else begin
						neg_q <= sum[66];
						dup_q <= 1'b0;
						state_q <= S_DIV;
					end
				end
				S_DIV: if (div_rsp.done) begin
					if (neg_q) out_y <= (div_rsp.quo > 64'h8000_0000) ? 32'h8000_0000
						: 32'(-div_rsp.quo);
					else out_y <= (div_rsp.quo > 64'h7fff_ffff) ? 32'h7fff_ffff
						: div_rsp.quo[31:0];
					state_q <= S_OUT;
				end
				S_OUT: begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		den_q <= xb_q - xa_q;
		if (state_q == S_SUM && dup_q) begin
			num_q <= sum[66] ? 64'(-sum) : sum[63:0];
		end
	end

	assign out_count = 7'(count_q);
endmodule
`default_nettype wire

[design/piecewise_linear_interpolator_unit.sv]
// top level of the piecewise linear interpolator
// usage: items arrive on s_axis (tuser = kind, tdata = x_value | y_value),
// one result leaves on m_axis per item (tdata = y_result | status | point_count).
// kind 0 clears the table, 1 inserts a breakpoint in ascending x order,
// 2 queries an interpolated value, 3 is answered with status ok.
// after accept, clear, kind 3 and query on a short table go straight to the output;
// load runs the search (up to 7 probes), the duplicate and full check, the shift of
// later entries and write; a query adds two reads, a multiply and the 64-step divider.
// one item is in flight at a time; a new item can be taken in the cycle after the
// previous result has left the output register.
// breakpoints live in one single-port memory (x and y per word, registered read).
// reset clears the point count and the handshake; the memory is not cleared,
// entries at or above the count are never used.
// when the receiver stalls, the result holds in the output register and the
// input stays not ready.
`timescale 1ns / 1ps
`default_nettype none
module piecewise_linear_interpolator_unit (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire [63:0]  s_axis_tdata,  // x_value[31:0], y_value[63:32]
	input  wire [1:0]   s_axis_tuser,  // kind
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [47:0] m_axis_tdata   // y_result[31:0], status[33:32], point_count[40:34]
);
	logic                       ram_we;
	logic [pli_pkg::AddrW-1:0]  ram_addr;
	logic [63:0]                ram_wdata, ram_rdata;
	pli_pkg::div_req_t          div_req;
	pli_pkg::div_rsp_t          div_rsp;
	logic [31:0]                y_res;
	logic [1:0]                 stat;
	logic [6:0]                 cnt;

	pli_ram u_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	pli_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));

	pli_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_kind(s_axis_tuser),
		.in_x(s_axis_tdata[31:0]), .in_y(s_axis_tdata[63:32]),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_y(y_res), .out_status(stat), .out_count(cnt),
		.ram_we(ram_we), .ram_addr(ram_addr), .ram_wdata(ram_wdata),
		.ram_rdata(ram_rdata), .div_req(div_req), .div_rsp(div_rsp)
	);

	// result word, zero padded to whole bytes
	assign m_axis_tdata = {7'd0, cnt, stat, y_res};
endmodule
`default_nettype wire

[design/pli_checker.sv]
// port-level checks for the interpolator, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module pli_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_axis_tvalid,
	input wire        s_axis_tready,
	input wire [1:0]  s_axis_tuser,
	input wire        m_axis_tvalid,
	input wire        m_axis_tready,
	input wire [47:0] m_axis_tdata
);
	// no new item while a result waits
	a_one_flight: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("item taken while result pending");
	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");
	// point count never exceeds table size
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[40:34] <= 7'(pli_pkg::MaxPoints))
		else $error("point count out of range");
	// clear answers with an empty table after accept
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser == pli_pkg::KIND_CLEAR
		|-> ##2 m_axis_tvalid && m_axis_tdata[40:34] == 7'd0)
		else $error("clear did not empty table");
endmodule

bind piecewise_linear_interpolator_unit pli_checker u_pli_checker (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready), .s_axis_tuser(s_axis_tuser),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
